// ----- hw/rtl/pss_pkg.sv -----
package pss_pkg;
  localparam int unsigned IN_COORD_W = 16;
  localparam int unsigned CENT_W     = 24;
  localparam int unsigned BOX_W      = 17;
  localparam int unsigned LEN_W      = 40;
  localparam int unsigned CNT_W      = 13;

  typedef struct packed {
    logic [IN_COORD_W-1:0] point_x;
    logic [IN_COORD_W-1:0] point_y;
    logic                  last_point;
  } pss_in_t;

  typedef struct packed {
    logic [CENT_W-1:0]     centroid_x;
    logic [CENT_W-1:0]     centroid_y;
    logic [IN_COORD_W-1:0] box_left;
    logic [IN_COORD_W-1:0] box_top;
    logic [BOX_W-1:0]      box_width;
    logic [BOX_W-1:0]      box_height;
    logic [LEN_W-1:0]      path_length;
    logic [CNT_W-1:0]      point_count;
    logic                  overflow;
  } pss_out_t;

  // Control toward a serial unit and its busy and done report
  typedef struct packed {
    logic start;
  } pss_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pss_sts_t;
endpackage

// ----- hw/rtl/pss_in_if.sv -----
interface pss_in_if;
  import pss_pkg::*;
  logic    valid;
  logic    ready;
  pss_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/pss_out_if.sv -----
interface pss_out_if;
  import pss_pkg::*;
  logic     valid;
  logic     ready;
  pss_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/point_set_statistics_unit.sv -----
// Contour statistics over a stream of points. The first point of a set is
// taken in S_IDLE. Every later point is taken, then the squared step is
// formed (differences, squares, sum, start), the bit-serial square root
// runs at one root bit a cycle, and the root is folded into the path
// length before the next ready. A last point with closing enabled runs a
// second root pass. Then the two centroid divisions run one after the
// other, and the result register is loaded. The next set streams in while
// a result waits there; a later result holds in its final state until the
// register has been handed off.
module point_set_statistics_unit #(
  parameter int unsigned MAX_POINTS = 4096,
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_wdata,
  pss_in_if.sink    in_ch,
  pss_out_if.source out_ch
);
  import pss_pkg::*;

  localparam int unsigned CNTB  = $clog2(MAX_POINTS + 1);
  localparam int unsigned SUM_W = COORD_BITS + CNTB;
  localparam int unsigned RAD_W = 2 * COORD_BITS + 2;
  localparam int unsigned ROOT_W = COORD_BITS + 1 + FRAC_BITS;
  localparam int unsigned NUM_W = SUM_W + FRAC_BITS;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [CNTB-1:0]  CNT_MAX = CNTB'(MAX_POINTS);
  localparam logic [1:0]       SQ_START = 2'd3;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SQ    = 7'b0000010,
    S_ROOT  = 7'b0000100,
    S_CLOSE = 7'b0001000,
    S_DIVX  = 7'b0010000,
    S_DIVY  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r;
  logic close_r;
  logic [COORD_BITS-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic [COORD_BITS-1:0] cur_x_r, cur_y_r;
  logic [COORD_BITS-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic [SUM_W-1:0] sum_x_r, sum_y_r;
  logic [LEN_W-1:0] len_r;
  logic [CNTB-1:0]  cnt_r;
  logic             sat_r, last_r, closing_r;
  logic [COORD_BITS-1:0] dx_r, dy_r;
  logic [RAD_W-1:0] rad_r;
  logic [2*COORD_BITS-1:0] dxx_r, dyy_r;
  logic [1:0]       sq_ph_r;
  logic [NUM_W-1:0] cx_r;
  pss_out_t         res_r;
  logic             ov_r;
  logic             res_load;

  pss_ctl_t sq_ctl, dv_ctl;
  pss_sts_t sq_sts, dv_sts;
  logic [ROOT_W-1:0] root;
  logic [NUM_W-1:0]  quo;
  logic [NUM_W-1:0]  div_num;
  logic [CNTB:0]     div_den;

  logic [COORD_BITS-1:0] xi, yi, ax, ay, bx, by;
  logic [LEN_W:0]        len_sum;

  pss_sqrt #(.RAD_W(RAD_W), .ROOT_W(ROOT_W)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .ctl(sq_ctl), .radicand(rad_r),
    .sts(sq_sts), .root(root));

  pss_div #(.NUM_W(NUM_W), .DEN_W(CNTB + 1)) u_div (
    .clk(clk), .rst_n(rst_n), .ctl(dv_ctl), .num(div_num), .den(div_den),
    .sts(dv_sts), .quo(quo));

  assign xi = in_ch.data.point_x[COORD_BITS-1:0];
  assign yi = in_ch.data.point_y[COORD_BITS-1:0];
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.data  = res_r;

  // Load the result register when it is empty or handed off this cycle
  assign res_load = (state_r == S_OUT) && (!ov_r || out_ch.ready);

  // Segment end points: step from previous, or closing back to first
  assign ax = closing_r ? first_x_r : prev_x_r;
  assign ay = closing_r ? first_y_r : prev_y_r;
  assign bx = cur_x_r;
  assign by = cur_y_r;
  assign len_sum = {1'b0, len_r} + (LEN_W+1)'(root);
  assign div_num = (state_r == S_DIVY) ? {sum_y_r, FRAC_BITS'(0)}
                                       : {sum_x_r, FRAC_BITS'(0)};
  assign div_den = {1'b0, cnt_r};

  always_comb begin
    sq_ctl.start = (state_r == S_SQ) && (sq_ph_r == SQ_START);
    dv_ctl.start = ((state_r == S_DIVX) || (state_r == S_DIVY)) &&
                   !dv_sts.busy && !dv_sts.done;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) close_r <= 1'b0;
    else if (cfg_we) close_r <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0; sat_r <= 1'b0; len_r <= '0;
      sum_x_r <= '0; sum_y_r <= '0;
      sq_ph_r <= '0; closing_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            cur_x_r <= xi; cur_y_r <= yi;
            last_r  <= in_ch.data.last_point;
            closing_r <= 1'b0;
            if (cnt_r < CNT_MAX) begin
              cnt_r   <= cnt_r + CNTB'(1);
              sum_x_r <= sum_x_r + SUM_W'(xi);
              sum_y_r <= sum_y_r + SUM_W'(yi);
            end else begin
              sat_r <= 1'b1;
            end
            if (cnt_r == '0) begin
              first_x_r <= xi; first_y_r <= yi;
              min_x_r <= xi; max_x_r <= xi; min_y_r <= yi; max_y_r <= yi;
              prev_x_r <= xi; prev_y_r <= yi;
              if (in_ch.data.last_point) begin
                state_r <= S_DIVX;
              end
            end else begin
              if (xi < min_x_r) min_x_r <= xi;
              if (xi > max_x_r) max_x_r <= xi;
              if (yi < min_y_r) min_y_r <= yi;
              if (yi > max_y_r) max_y_r <= yi;
              state_r <= S_SQ; sq_ph_r <= '0;
            end
          end
        end
        S_SQ: begin
          // Absolute differences, squares, radicand, then start the root
          sq_ph_r <= sq_ph_r + 2'd1;
          case (sq_ph_r)
            2'd0: begin
              dx_r <= (ax > bx) ? ax - bx : bx - ax;
              dy_r <= (ay > by) ? ay - by : by - ay;
            end
            2'd1: begin
              dxx_r <= dx_r * dx_r;
              dyy_r <= dy_r * dy_r;
            end
            2'd2: rad_r <= RAD_W'(dxx_r) + RAD_W'(dyy_r);
            default: state_r <= S_ROOT;
          endcase
        end
        S_ROOT: begin
          if (sq_sts.done) begin
            if (len_sum[LEN_W]) begin
              len_r <= LEN_MAX; sat_r <= 1'b1;
            end else begin
              len_r <= len_sum[LEN_W-1:0];
            end
            if (!closing_r) begin
              prev_x_r <= cur_x_r; prev_y_r <= cur_y_r;
            end
            if (last_r && !closing_r && close_r) begin
              closing_r <= 1'b1; state_r <= S_SQ; sq_ph_r <= '0;
            end else if (last_r) begin
              state_r <= S_DIVX;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_CLOSE: state_r <= S_IDLE;
        S_DIVX: begin
          if (dv_sts.done) begin
            cx_r <= quo; state_r <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (dv_sts.done) state_r <= S_OUT;
        end
        S_OUT: begin
          // Clear the set once the result register takes it
          if (res_load) begin
            cnt_r <= '0; sat_r <= 1'b0; len_r <= '0;
            sum_x_r <= '0; sum_y_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result valid: set on load, drop on handoff
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (res_load) ov_r <= 1'b1;
    else if (out_ch.ready) ov_r <= 1'b0;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r.centroid_x  <= CENT_W'(cx_r);
      res_r.centroid_y  <= CENT_W'(quo);
      res_r.box_left    <= IN_COORD_W'(min_x_r);
      res_r.box_top     <= IN_COORD_W'(min_y_r);
      res_r.box_width   <= BOX_W'({1'b0, max_x_r} - {1'b0, min_x_r} + 1'b1);
      res_r.box_height  <= BOX_W'({1'b0, max_y_r} - {1'b0, min_y_r} + 1'b1);
      res_r.path_length <= len_r;
      res_r.point_count <= CNT_W'(cnt_r);
      res_r.overflow    <= sat_r;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.data))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    sq_sts.busy |-> !dv_sts.busy)
    else $error("root and divider overlap");
endmodule

// ----- hw/rtl/pss_sqrt.sv -----
// Bit-serial integer square root: one result bit per cycle, radicand
// shifted in two bits a cycle from a shift register.
module pss_sqrt #(
  parameter int unsigned RAD_W  = 34,
  parameter int unsigned ROOT_W = 25
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pss_pkg::pss_ctl_t         ctl,
  input  logic [RAD_W-1:0]          radicand,
  output pss_pkg::pss_sts_t         sts,
  output logic [ROOT_W-1:0]         root
);
  import pss_pkg::*;
  localparam int unsigned PAD_W = 2 * ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned CW    = $clog2(ROOT_W + 1);

  logic [PAD_W-1:0]  sh_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r;
  logic [REM_W-1:0]  rem_s, trial;

  always_comb begin
    rem_s = {rem_r[REM_W-3:0], sh_r[PAD_W-1 -: 2]};
    trial = {root_r, 2'b01};
  end

  // Step one root bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(ROOT_W);
        sh_r   <= PAD_W'(radicand) << (PAD_W - RAD_W);
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        sh_r <= sh_r << 2;
        if (rem_s >= trial) begin
          rem_r  <= rem_s - trial;
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_s;
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts  = '{busy: busy_r, done: done_r};
  assign root = root_r;
endmodule

// ----- hw/rtl/pss_div.sv -----
// Restoring divider, one quotient bit per cycle.
module pss_div #(
  parameter int unsigned NUM_W = 36,
  parameter int unsigned DEN_W = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pss_pkg::pss_ctl_t ctl,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output pss_pkg::pss_sts_t sts,
  output logic [NUM_W-1:0]  quo
);
  import pss_pkg::*;
  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r;
  logic [DEN_W:0]   rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   rem_s;

  assign rem_s = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_W);
        q_r    <= num;
        den_r  <= den;
        rem_r  <= '0;
      end else if (busy_r) begin
        // Shift in next dividend bit, subtract when it fits
        if (rem_s >= {1'b0, den_r}) begin
          rem_r <= rem_s - {1'b0, den_r};
          q_r   <= {q_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_s;
          q_r   <= {q_r[NUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts = '{busy: busy_r, done: done_r};
  assign quo = q_r;
endmodule

// ----- sim/point_set_statistics_unit_test.sv -----
`timescale 1ns / 1ps

module point_set_statistics_unit_test;
  import pss_pkg::*;

  localparam int unsigned POINT_LIMIT = 4096;
  localparam int unsigned FRAC = 8;
  localparam logic [39:0] LENGTH_CEILING = 40'hFF_FFFF_FFFF;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 200;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  pss_in_if in_ch ();
  pss_out_if out_ch ();

  point_set_statistics_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Contour state of the predictor
  logic        close_loop;
  logic [15:0] start_x, start_y, last_x, last_y;
  logic [27:0] total_x, total_y;
  logic [15:0] low_x, high_x, low_y, high_y;
  logic [39:0] run_length;
  logic [12:0] points_seen;
  logic        saturated;

  pss_out_t summary_queue[$];
  int error_count;
  int summary_count;
  int idle_cycles;
  int sets_closed;

  function automatic logic [39:0] root_q8(logic [63:0] s);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] trial;
    logic [1:0]  pair;
    rem = 0;
    root = 0;
    for (int i = 0; i < 32 + FRAC; i++) begin
      pair = (i < 32) ? s[63 - 2*i -: 2] : 2'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[39:0];
  endfunction

  function automatic logic [39:0] segment_length(logic [15:0] ax, logic [15:0] ay,
                                                 logic [15:0] bx, logic [15:0] by);
    logic [63:0] dx;
    logic [63:0] dy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return root_q8(dx * dx + dy * dy);
  endfunction

  task automatic accumulate_length(logic [39:0] d);
    if (d > LENGTH_CEILING - run_length) begin
      run_length = LENGTH_CEILING;
      saturated = 1'b1;
    end else begin
      run_length = run_length + d;
    end
  endtask

  task automatic clear_contour();
    start_x = 0; start_y = 0; last_x = 0; last_y = 0;
    total_x = 0; total_y = 0;
    low_x = 0; high_x = 0; low_y = 0; high_y = 0;
    run_length = 0;
    points_seen = 0;
    saturated = 0;
  endtask

  // Advance the predictor by one point, produce a summary on the last one
  task automatic predict_point(pss_in_t p, output logic produced, output pss_out_t s);
    logic [63:0] cx;
    logic [63:0] cy;
    produced = 1'b0;
    s = '0;
    if (points_seen == 0) begin
      start_x = p.point_x; start_y = p.point_y;
      low_x = p.point_x; high_x = p.point_x;
      low_y = p.point_y; high_y = p.point_y;
      run_length = 0;
      saturated = 0;
    end else begin
      accumulate_length(segment_length(last_x, last_y, p.point_x, p.point_y));
      if (p.point_x < low_x) low_x = p.point_x;
      if (p.point_x > high_x) high_x = p.point_x;
      if (p.point_y < low_y) low_y = p.point_y;
      if (p.point_y > high_y) high_y = p.point_y;
    end
    last_x = p.point_x;
    last_y = p.point_y;
    if (points_seen < POINT_LIMIT) begin
      points_seen = points_seen + 1;
      total_x = total_x + p.point_x;
      total_y = total_y + p.point_y;
    end else begin
      saturated = 1'b1;
    end
    if (p.last_point) begin
      if (close_loop)
        accumulate_length(segment_length(p.point_x, p.point_y, start_x, start_y));
      cx = (64'(total_x) << FRAC) / points_seen;
      cy = (64'(total_y) << FRAC) / points_seen;
      s.centroid_x = cx[23:0];
      s.centroid_y = cy[23:0];
      s.box_left = low_x;
      s.box_top = low_y;
      s.box_width = 17'(high_x) - 17'(low_x) + 17'd1;
      s.box_height = 17'(high_y) - 17'(low_y) + 17'd1;
      s.path_length = run_length;
      s.point_count = points_seen;
      s.overflow = saturated;
      produced = 1'b1;
      clear_contour();
    end
  endtask

  // Directed table: point, and a typed summary where one is obvious
  typedef struct {
    pss_in_t  p;
    logic     typed;
    pss_out_t s;
  } directed_row_t;

  directed_row_t directed_rows[$];

  function automatic pss_in_t make_point(logic [15:0] x, logic [15:0] y, logic last);
    pss_in_t p;
    p.point_x = x;
    p.point_y = y;
    p.last_point = last;
    return p;
  endfunction

  function automatic pss_out_t make_summary(logic [23:0] cx, logic [23:0] cy,
                                            logic [15:0] l, logic [15:0] t,
                                            logic [16:0] w, logic [16:0] h,
                                            logic [39:0] len, logic [12:0] n,
                                            logic ov);
    pss_out_t s;
    s.centroid_x = cx; s.centroid_y = cy;
    s.box_left = l; s.box_top = t;
    s.box_width = w; s.box_height = h;
    s.path_length = len; s.point_count = n; s.overflow = ov;
    return s;
  endfunction

  task automatic add_row(pss_in_t p, logic typed, pss_out_t s);
    directed_row_t r;
    r.p = p;
    r.typed = typed;
    r.s = s;
    directed_rows.insert(directed_rows.size(), r);
  endtask

  // Send one transaction after a random gap and record its expectation
  task automatic send_point(pss_in_t p, logic typed, pss_out_t typed_summary);
    int gap;
    logic produced;
    pss_out_t s;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= p;
    do @(posedge clk); while (!in_ch.ready);
    predict_point(p, produced, s);
    if (produced) begin
      if (typed && s !== typed_summary) begin
        $error("typed summary disagrees with predictor: %h vs %h", typed_summary, s);
        error_count++;
      end
      summary_queue.insert(summary_queue.size(), typed ? typed_summary : s);
    end
  endtask

  // Hold the input idle until every expected result has come
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (summary_queue.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_close(logic v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    close_loop = v;
  endtask

  // Send one random contour of len points; the caller picks mostly short, seldom long
  task automatic send_contour(int len, int spread);
    logic [15:0] bx;
    logic [15:0] by;
    pss_in_t p;
    bx = $urandom;
    by = $urandom;
    for (int i = 0; i < len; i++) begin
      if (spread == 0) begin
        p.point_x = $urandom;
        p.point_y = $urandom;
      end else begin
        p.point_x = bx + $urandom_range(0, spread);
        p.point_y = by + $urandom_range(0, spread);
      end
      p.last_point = (i == len - 1);
      send_point(p, 1'b0, '0);
    end
  endtask

  // Result sink: draw a wait per transaction, then hold ready until taken
  initial begin
    int wait_cycles;
    out_ch.ready = 1'b0;
    forever begin
      wait_cycles = $urandom_range(0, 6);
      if (wait_cycles != 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_ch.valid && out_ch.ready));
    end
  end

  // Compare each result transaction against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (summary_queue.size() == 0) begin
        $error("result with no expectation: %h", out_ch.data);
        error_count++;
      end else begin
        pss_out_t e;
        pss_out_t a;
        e = summary_queue.pop_front();
        a = out_ch.data;
        summary_count++;
        if (a.centroid_x !== e.centroid_x) begin
          $error("centroid_x expected %0d actual %0d", e.centroid_x, a.centroid_x);
          error_count++;
        end
        if (a.centroid_y !== e.centroid_y) begin
          $error("centroid_y expected %0d actual %0d", e.centroid_y, a.centroid_y);
          error_count++;
        end
        if (a.box_left !== e.box_left) begin
          $error("box_left expected %0d actual %0d", e.box_left, a.box_left);
          error_count++;
        end
        if (a.box_top !== e.box_top) begin
          $error("box_top expected %0d actual %0d", e.box_top, a.box_top);
          error_count++;
        end
        if (a.box_width !== e.box_width) begin
          $error("box_width expected %0d actual %0d", e.box_width, a.box_width);
          error_count++;
        end
        if (a.box_height !== e.box_height) begin
          $error("box_height expected %0d actual %0d", e.box_height, a.box_height);
          error_count++;
        end
        if (a.path_length !== e.path_length) begin
          $error("path_length expected %0d actual %0d", e.path_length, a.path_length);
          error_count++;
        end
        if (a.point_count !== e.point_count) begin
          $error("point_count expected %0d actual %0d", e.point_count, a.point_count);
          error_count++;
        end
        if (a.overflow !== e.overflow) begin
          $error("overflow expected %0d actual %0d", e.overflow, a.overflow);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog expired");
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int random_points;
    int len;
    error_count = 0;
    summary_count = 0;
    idle_cycles = 0;
    sets_closed = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    close_loop = 1'b0;
    clear_contour();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with the path open: single points, extremes, two-point and three-point sets
    add_row(make_point(16'd0, 16'd0, 1'b1), 1'b1,
            make_summary(0, 0, 0, 0, 17'd1, 17'd1, 0, 13'd1, 1'b0));
    add_row(make_point(16'hFFFF, 16'hFFFF, 1'b1), 1'b1,
            make_summary(24'hFFFF00, 24'hFFFF00, 16'hFFFF, 16'hFFFF, 17'd1, 17'd1,
                         0, 13'd1, 1'b0));
    add_row(make_point(16'd0, 16'd0, 1'b0), 1'b0, '0);
    add_row(make_point(16'hFFFF, 16'hFFFF, 1'b1), 1'b0, '0);
    add_row(make_point(16'd0, 16'd0, 1'b0), 1'b0, '0);
    add_row(make_point(16'd3, 16'd4, 1'b1), 1'b1,
            make_summary(24'h180, 24'h200, 0, 0, 17'd4, 17'd5, 40'd1280, 13'd2, 1'b0));
    add_row(make_point(16'hAAAA, 16'h5555, 1'b0), 1'b0, '0);
    add_row(make_point(16'h5555, 16'hAAAA, 1'b0), 1'b0, '0);
    add_row(make_point(16'h0001, 16'hFFFE, 1'b1), 1'b0, '0);
    foreach (directed_rows[i])
      send_point(directed_rows[i].p, directed_rows[i].typed, directed_rows[i].s);
    wait_drained();

    // Closed path: single point, triangle, full-range square
    write_close(1'b1);
    directed_rows.delete();
    add_row(make_point(16'h1234, 16'h4321, 1'b1), 1'b1,
            make_summary(24'h123400, 24'h432100, 16'h1234, 16'h4321, 17'd1, 17'd1,
                         0, 13'd1, 1'b0));
    add_row(make_point(16'd0, 16'd0, 1'b0), 1'b0, '0);
    add_row(make_point(16'd3, 16'd0, 1'b0), 1'b0, '0);
    add_row(make_point(16'd3, 16'd4, 1'b1), 1'b0, '0);
    add_row(make_point(16'd0, 16'd0, 1'b0), 1'b0, '0);
    add_row(make_point(16'hFFFF, 16'd0, 1'b0), 1'b0, '0);
    add_row(make_point(16'hFFFF, 16'hFFFF, 1'b0), 1'b0, '0);
    add_row(make_point(16'd0, 16'hFFFF, 1'b1), 1'b0, '0);
    foreach (directed_rows[i])
      send_point(directed_rows[i].p, directed_rows[i].typed, directed_rows[i].s);
    wait_drained();

    // Random contours, switching the closing option between phases
    random_points = 0;
    while (random_points < 1580) begin
      if ($urandom_range(0, 7) == 0) begin
        wait_drained();
        write_close(1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 9) == 0) len = $urandom_range(40, 120);
      else len = $urandom_range(1, 12);
      send_contour(len, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300));
      if (close_loop) sets_closed++;
      random_points += len;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d summaries over directed corners and open and closed paths,",
             summary_count);
    $display("%0d random points (%0d closed contours)", random_points, sets_closed);
    if (error_count == 0 && summary_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
